### rtl/core/dpfc_pkg.sv
package dpfc_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_WR_SESSION = 2'd0,
        CMD_WR_FILTER  = 2'd1,
        CMD_CLASSIFY   = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    // session word indexes
    localparam logic [3:0] SW_V4      = 4'd0;
    localparam logic [3:0] SW_V6_HI   = 4'd1;
    localparam logic [3:0] SW_V6_LO   = 4'd2;
    localparam logic [3:0] SW_DEFAULT = 4'd3;

    // filter word indexes
    localparam logic [3:0] FW_PORTS = 4'd8;
    localparam logic [3:0] FW_META  = 4'd9;

    // protocol numbers with port checks
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // input tdata layout widths
    localparam int IN_W  = 2 + 6 + 4 + 64 + 1 + 64 * 4 + 8 + 16 + 16;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;

    typedef struct packed {
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  protocol;
        logic [63:0] dst_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] src_addr_hi;
        logic        is_ipv6;
        logic [63:0] word_data;
        logic [3:0]  word_index;
        logic [5:0]  entry_index;
        logic [1:0]  cmd;
    } t_in_item;

    typedef struct packed {
        logic [3:0] bearer_id;
        logic [3:0] session_number;
        logic       dedicated;
        logic       found;
    } t_result;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SESS  = 6'b000010,
        ST_FMETA = 6'b000100,
        ST_FADDR = 6'b001000,
        ST_FPORT = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

endpackage

### rtl/core/downlink_packet_filter_classifier_top.sv
// Channel  Dir  Handshake                       Payload
// s_axis   in   i_s_axis_tvalid/o_s_axis_tready  i_s_axis_tdata (command item)
// m_axis   out  o_m_axis_tvalid/i_m_axis_tready  o_m_axis_tdata (result item)
//
// A classify walks the sessions one per cycle (up to NUM_SESSIONS), then,
// once a session with a valid default matches, each filter until the first
// dedicated match. Every filter RAM read is registered; the meta word arrives
// with the first address value word, then a candidate reads the rest of its
// value/mask pairs (8 words for IPv6, 4 for IPv4, stopping at a mismatch)
// and then checks ports. All address words go through one shared 64-bit
// mask/compare unit, and each filter RAM has one read port.
// Reset (i_rst_n low, synchronous) clears the valid flags; no clearing pass.
// Input is not ready while a classify runs or its result waits on m_axis.
module downlink_packet_filter_classifier_top #(
    parameter int NUM_SESSIONS = 16,
    parameter int NUM_FILTERS  = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // from bit 0: cmd, entry_index, word_index, word_data, is_ipv6,
    // src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, protocol,
    // src_port, dst_port, zero fill
    input  logic [dpfc_pkg::IN_TW-1:0]   i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // from bit 0: found, dedicated, session_number, bearer_id
    output logic [15:0]                  o_m_axis_tdata
);
    import dpfc_pkg::*;

    localparam int SW = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
    localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    t_in_item in_item;
    assign in_item = t_in_item'(i_s_axis_tdata[IN_W-1:0]);

    // session and filter stores
    logic [31:0] m_s_v4  [NUM_SESSIONS];
    logic [63:0] m_s_hi  [NUM_SESSIONS];
    logic [63:0] m_s_lo  [NUM_SESSIONS];
    logic [3:0]  m_s_def [NUM_SESSIONS];
    logic [NUM_SESSIONS-1:0] r_s_v4_ok, r_s_v6_ok, r_s_def_ok;
    logic [63:0] m_f_addr [NUM_FILTERS*8];
    logic [63:0] m_f_port [NUM_FILTERS];
    logic [18:0] m_f_meta [NUM_FILTERS];
    logic [NUM_FILTERS-1:0] r_f_ok;

    t_state      r_state;
    t_in_item    r_pkt;
    logic [SW-1:0] r_sidx;
    logic [FW-1:0] r_fidx;
    logic [2:0]  r_widx;
    logic        r_match;
    t_result     r_res;
    logic        r_out_valid;
    logic [63:0] r_aword;
    logic [63:0] r_pword;
    logic [18:0] r_meta;
    logic        r_meta_ok;
    logic        r_rd_pend;

    wire acc = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_res};

    wire t_cmd cmd = t_cmd'(in_item.cmd);

    // table writes
    always_ff @(posedge i_clk) begin
        if (acc && cmd == CMD_WR_SESSION && 32'(in_item.entry_index) < NUM_SESSIONS) begin
            case (in_item.word_index)
                SW_V4:      m_s_v4[in_item.entry_index[SW-1:0]] <= in_item.word_data[31:0];
                SW_V6_HI:   m_s_hi[in_item.entry_index[SW-1:0]] <= in_item.word_data;
                SW_V6_LO:   m_s_lo[in_item.entry_index[SW-1:0]] <= in_item.word_data;
                SW_DEFAULT: m_s_def[in_item.entry_index[SW-1:0]] <= in_item.word_data[3:0];
                default: ;
            endcase
        end
        if (acc && cmd == CMD_WR_FILTER && 32'(in_item.entry_index) < NUM_FILTERS) begin
            if (!in_item.word_index[3])
                m_f_addr[{in_item.entry_index[FW-1:0], in_item.word_index[2:0]}]
                    <= in_item.word_data;
            else if (in_item.word_index == FW_PORTS)
                m_f_port[in_item.entry_index[FW-1:0]] <= in_item.word_data;
            else if (in_item.word_index == FW_META)
                m_f_meta[in_item.entry_index[FW-1:0]] <= in_item.word_data[18:0];
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v4_ok <= '0; r_s_v6_ok <= '0; r_s_def_ok <= '0; r_f_ok <= '0;
        end else begin
            if (acc && cmd == CMD_WR_SESSION && 32'(in_item.entry_index) < NUM_SESSIONS) begin
                if (in_item.word_index == SW_V4) begin
                    r_s_v4_ok[in_item.entry_index[SW-1:0]] <= in_item.word_data[32];
                    r_s_v6_ok[in_item.entry_index[SW-1:0]] <= in_item.word_data[33];
                end
                if (in_item.word_index == SW_DEFAULT)
                    r_s_def_ok[in_item.entry_index[SW-1:0]] <= in_item.word_data[4];
            end
            if (acc && cmd == CMD_WR_FILTER && 32'(in_item.entry_index) < NUM_FILTERS
                    && in_item.word_index == FW_META)
                r_f_ok[in_item.entry_index[FW-1:0]] <= in_item.word_data[19];
        end
    end

    // registered filter RAM reads (one address port each)
    logic [FW-1:0] rd_f;
    logic [2:0]    rd_w;
    always_ff @(posedge i_clk) begin
        r_aword   <= m_f_addr[{rd_f, rd_w}];
        r_pword   <= m_f_port[rd_f];
        r_meta    <= m_f_meta[rd_f];
        r_meta_ok <= r_f_ok[rd_f];
    end

    // session compare, one entry a cycle
    wire s_hit = r_pkt.is_ipv6
        ? (r_s_v6_ok[r_sidx] && m_s_hi[r_sidx] == r_pkt.dst_addr_hi
           && m_s_lo[r_sidx] == r_pkt.dst_addr_lo)
        : (r_s_v4_ok[r_sidx] && m_s_v4[r_sidx] == r_pkt.dst_addr_hi[63:32]);

    wire [7:0] f_proto = r_meta[12:5];
    wire f_cand = r_meta_ok && r_meta[18:13] == 6'(r_sidx) && r_meta[3:0] != 4'd0
                  && r_meta[4];
    wire v6 = r_pkt.is_ipv6;

    function automatic logic port_ok(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
        port_ok = !((lo != 16'd0 && p < lo) || (hi != 16'd0 && p > hi));
    endfunction

    wire prt_ok = (f_proto == 8'd0) || ((f_proto == r_pkt.protocol) &&
        (!(f_proto == PROTO_TCP || f_proto == PROTO_UDP) ||
         (port_ok(r_pkt.src_port, r_pword[15:0], r_pword[31:16]) &&
          port_ok(r_pkt.dst_port, r_pword[47:32], r_pword[63:48]))));

    // address words are visited as pairs: value word then mask word
    // r_widx selects: bit2 src/dst, bit0 hi/lo; r_mphase marks mask reads
    logic        r_mphase;
    logic [63:0] r_val;
    logic [63:0] pkt_w_sel, himask;
    wire [2:0] aw_val = {r_widx[2], 1'b0, r_widx[0]};
    wire [2:0] aw_msk = {r_widx[2], 1'b1, r_widx[0]};
    always_comb begin
        pkt_w_sel = r_widx[2] ? (r_widx[0] ? r_pkt.dst_addr_lo : r_pkt.dst_addr_hi)
                              : (r_widx[0] ? r_pkt.src_addr_lo : r_pkt.src_addr_hi);
        himask = v6 ? {64{1'b1}} : {{32{1'b1}}, 32'd0};
    end
    // shared mask/compare unit: packet word under mask vs filter value
    wire word_eq = ((pkt_w_sel & r_aword & himask) == (r_val & himask));
    wire last_fidx = 32'(r_fidx) == NUM_FILTERS - 1;

    always_comb begin
        rd_f = r_fidx;
        rd_w = r_mphase ? aw_msk : aw_val;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_out_valid <= 1'b0; r_rd_pend <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (acc && cmd == CMD_CLASSIFY) begin
                    r_pkt <= in_item; r_sidx <= '0; r_res <= '0;
                    r_state <= ST_SESS;
                end
                ST_SESS: begin
                    if (s_hit) begin
                        if (r_s_def_ok[r_sidx]) begin
                            r_res.found <= 1'b1;
                            r_res.session_number <= 4'(r_sidx);
                            r_res.bearer_id <= m_s_def[r_sidx];
                            r_fidx <= '0; r_widx <= '0; r_mphase <= 1'b0;
                            r_rd_pend <= 1'b1;
                            r_state <= ST_FMETA;
                        end else r_state <= ST_OUT;
                    end else if (32'(r_sidx) == NUM_SESSIONS - 1) r_state <= ST_OUT;
                    else r_sidx <= r_sidx + 1'b1;
                end
                ST_FMETA: begin
                    // meta read issued last cycle; value word read also in flight
                    if (r_rd_pend) r_rd_pend <= 1'b0;
                    else if (f_cand) begin
                        r_val <= r_aword; r_mphase <= 1'b1; r_rd_pend <= 1'b1;
                        r_state <= ST_FADDR;
                    end else if (last_fidx) r_state <= ST_OUT;
                    else begin
                        r_fidx <= r_fidx + 1'b1; r_rd_pend <= 1'b1;
                    end
                end
                ST_FADDR: begin
                    if (r_rd_pend) r_rd_pend <= 1'b0;
                    else if (!r_mphase) begin
                        r_val <= r_aword; r_mphase <= 1'b1; r_rd_pend <= 1'b1;
                    end else if (!word_eq) begin
                        r_widx <= '0; r_mphase <= 1'b0;
                        if (last_fidx) r_state <= ST_OUT;
                        else begin
                            r_fidx <= r_fidx + 1'b1; r_rd_pend <= 1'b1;
                            r_state <= ST_FMETA;
                        end
                    end else begin
                        r_mphase <= 1'b0;
                        // v4 compares hi words only
                        if (r_widx == 3'd4 && !v6) r_state <= ST_FPORT;
                        else if (r_widx == 3'd5) r_state <= ST_FPORT;
                        else begin
                            r_widx <= (r_widx == 3'd1 || (r_widx == 3'd0 && !v6))
                                      ? 3'd4 : r_widx + 1'b1;
                            r_rd_pend <= 1'b1;
                        end
                    end
                end
                ST_FPORT: begin
                    r_widx <= '0;
                    if (prt_ok) begin
                        r_res.dedicated <= 1'b1; r_res.bearer_id <= r_meta[3:0];
                        r_state <= ST_OUT;
                    end else if (last_fidx) r_state <= ST_OUT;
                    else begin
                        r_fidx <= r_fidx + 1'b1; r_rd_pend <= 1'b1;
                        r_state <= ST_FMETA;
                    end
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1; r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_s_axis_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result dropped");
    a_ded_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[0])
        else $error("dedicated without session");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state code");

endmodule

### verif/tb_downlink_packet_filter_classifier_top.sv
module tb_downlink_packet_filter_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dpfc_pkg::*;

    // Shadow of the session and filter tables plus the queue of pending
    // classification results.
    class bearer_scoreboard;
        logic [33:0] sess_v4 [16];
        logic [63:0] sess_v6_hi [16];
        logic [63:0] sess_v6_lo [16];
        logic [4:0]  sess_dflt [16];
        logic [63:0] filt_addr [64][8];
        logic [63:0] filt_ports [64];
        logic [19:0] filt_meta [64];
        t_result     exp_q [$];
        int          n_err;
        int          n_cls;
        int          n_found;
        int          n_ded;

        function new();
            foreach (sess_v4[i]) begin
                sess_v4[i] = '0;
                sess_v6_hi[i] = '0;
                sess_v6_lo[i] = '0;
                sess_dflt[i] = '0;
            end
            foreach (filt_meta[i]) begin
                filt_meta[i] = '0;
                filt_ports[i] = '0;
                for (int w = 0; w < 8; w++) filt_addr[i][w] = '0;
            end
        endfunction

        static function bit port_in(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
            return !((lo != 0 && p < lo) || (hi != 0 && p > hi));
        endfunction

        function bit filter_hit(int f, t_in_item it);
            logic [7:0]  proto;
            logic [63:0] pr;
            bit          ok;
            proto = filt_meta[f][12:5];
            pr = filt_ports[f];
            if (it.is_ipv6) begin
                ok = ((it.src_addr_hi & filt_addr[f][2]) == filt_addr[f][0])
                  && ((it.src_addr_lo & filt_addr[f][3]) == filt_addr[f][1])
                  && ((it.dst_addr_hi & filt_addr[f][6]) == filt_addr[f][4])
                  && ((it.dst_addr_lo & filt_addr[f][7]) == filt_addr[f][5]);
            end else begin
                ok = ((it.src_addr_hi[63:32] & filt_addr[f][2][63:32])
                      == filt_addr[f][0][63:32])
                  && ((it.dst_addr_hi[63:32] & filt_addr[f][6][63:32])
                      == filt_addr[f][4][63:32]);
            end
            if (!ok) return 0;
            if (proto == 0) return 1;
            if (proto != it.protocol) return 0;
            if (proto == PROTO_TCP || proto == PROTO_UDP)
                return port_in(it.src_port, pr[15:0], pr[31:16])
                    && port_in(it.dst_port, pr[47:32], pr[63:48]);
            return 1;
        endfunction

        // update the tables or queue the expected bearer for one accepted item
        function void note_item(t_in_item it);
            t_result r;
            int      s;
            bit      hit;
            r = '0;
            case (t_cmd'(it.cmd))
                CMD_WR_SESSION: begin
                    if (it.entry_index < 16) begin
                        case (it.word_index)
                            SW_V4:      sess_v4[it.entry_index[3:0]] = it.word_data[33:0];
                            SW_V6_HI:   sess_v6_hi[it.entry_index[3:0]] = it.word_data;
                            SW_V6_LO:   sess_v6_lo[it.entry_index[3:0]] = it.word_data;
                            SW_DEFAULT: sess_dflt[it.entry_index[3:0]] = it.word_data[4:0];
                            default: ;
                        endcase
                    end
                end
                CMD_WR_FILTER: begin
                    if (it.word_index < 8)
                        filt_addr[it.entry_index][it.word_index[2:0]] = it.word_data;
                    else if (it.word_index == FW_PORTS)
                        filt_ports[it.entry_index] = it.word_data;
                    else if (it.word_index == FW_META)
                        filt_meta[it.entry_index] = it.word_data[19:0];
                end
                CMD_CLASSIFY: begin
                    n_cls++;
                    hit = 0;
                    for (s = 0; s < 16; s++) begin
                        if (it.is_ipv6)
                            hit = sess_v4[s][33] && it.dst_addr_hi == sess_v6_hi[s]
                                  && it.dst_addr_lo == sess_v6_lo[s];
                        else
                            hit = sess_v4[s][32]
                                  && it.dst_addr_hi[63:32] == sess_v4[s][31:0];
                        if (hit) break;
                    end
                    if (hit && sess_dflt[s][4]) begin
                        r.found = 1;
                        r.session_number = s[3:0];
                        r.bearer_id = sess_dflt[s][3:0];
                        for (int f = 0; f < 64; f++) begin
                            if (filt_meta[f][19] && filt_meta[f][18:13] == 6'(s)
                                && filt_meta[f][3:0] != 0 && filt_meta[f][4]
                                && filter_hit(f, it)) begin
                                r.dedicated = 1;
                                r.bearer_id = filt_meta[f][3:0];
                                break;
                            end
                        end
                    end
                    exp_q.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [15:0] data);
            t_result got, want;
            got = data[9:0];
            if (exp_q.size() == 0) begin
                $error("result with nothing expected: %h", data);
                n_err++;
                return;
            end
            want = exp_q.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d got %0d", want.found, got.found);
                n_err++;
            end
            if (got.dedicated !== want.dedicated) begin
                $error("dedicated: expected %0d got %0d", want.dedicated, got.dedicated);
                n_err++;
            end
            if (got.session_number !== want.session_number) begin
                $error("session_number: expected %0d got %0d",
                       want.session_number, got.session_number);
                n_err++;
            end
            if (got.bearer_id !== want.bearer_id) begin
                $error("bearer_id: expected %0d got %0d", want.bearer_id, got.bearer_id);
                n_err++;
            end
            if (data[15:10] !== '0) begin
                $error("fill bits: expected 0 got %h", data[15:10]);
                n_err++;
            end
            n_found += want.found;
            n_ded += want.dedicated;
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_TW-1:0]     i_s_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [15:0]          o_m_axis_tdata;

    bearer_scoreboard sb;
    t_in_item         stim_q [$];
    bit               tx_burst;
    bit               rx_burst;
    bit               v6_written [16];
    bit               filt_full [64];
    logic [31:0]      v4_pool [4];
    logic [63:0]      v6_pool [4][2];
    logic [63:0]      src_pool [4][2];
    int               n_sent;

    downlink_packet_filter_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // item with every field random, so unused fields toggle as well
    function automatic t_in_item noise_item(t_cmd c);
        t_in_item it;
        it.cmd = c;
        it.entry_index = 6'($urandom);
        it.word_index = 4'($urandom);
        it.word_data = rnd64();
        it.is_ipv6 = 1'($urandom);
        it.src_addr_hi = rnd64();
        it.src_addr_lo = rnd64();
        it.dst_addr_hi = rnd64();
        it.dst_addr_lo = rnd64();
        it.protocol = 8'($urandom);
        it.src_port = 16'($urandom);
        it.dst_port = 16'($urandom);
        return it;
    endfunction

    function automatic void push_wr(t_cmd c, int entry, logic [3:0] word, logic [63:0] data);
        t_in_item it;
        it = noise_item(c);
        it.entry_index = 6'(entry);
        it.word_index = word;
        it.word_data = data;
        stim_q.push_back(it);
        if (c == CMD_WR_SESSION && word == SW_V6_LO && entry < 16) v6_written[entry] = 1;
    endfunction

    function automatic void push_cls(bit v6, logic [63:0] shi, logic [63:0] slo,
                                     logic [63:0] dhi, logic [63:0] dlo,
                                     logic [7:0] proto, logic [15:0] sp, logic [15:0] dp);
        t_in_item it;
        it = noise_item(CMD_CLASSIFY);
        it.is_ipv6 = v6;
        it.src_addr_hi = shi;
        it.src_addr_lo = slo;
        it.dst_addr_hi = dhi;
        it.dst_addr_lo = dlo;
        it.protocol = proto;
        it.src_port = sp;
        it.dst_port = dp;
        stim_q.push_back(it);
    endfunction

    function automatic logic [63:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return ~64'(0) << $urandom_range(0, 63);
            default: return rnd64();
        endcase
    endfunction

    // program a whole session entry; the v6 words go before the valid flags
    function automatic void gen_session(int s);
        int  k;
        bit  v4v, v6v;
        k = $urandom_range(0, 3);
        push_wr(CMD_WR_SESSION, s, SW_V6_HI, v6_pool[k][0]);
        push_wr(CMD_WR_SESSION, s, SW_V6_LO, $urandom_range(0, 5) == 0 ? rnd64()
                                                                         : v6_pool[k][1]);
        v4v = $urandom_range(0, 4) != 0;
        v6v = $urandom_range(0, 4) != 0;
        push_wr(CMD_WR_SESSION, s, SW_V4,
                {rnd64() & ~64'h3_FFFF_FFFF} | {30'd0, v6v, v4v, v4_pool[$urandom_range(0, 3)]});
        push_wr(CMD_WR_SESSION, s, SW_DEFAULT,
                {rnd64() & ~64'h1F} | {59'd0, $urandom_range(0, 7) != 0, 4'($urandom)});
    endfunction

    // program a whole filter entry, meta word last
    function automatic void gen_filter(int f);
        int          s, k;
        logic [63:0] m [4];
        logic [63:0] dhi, dlo;
        logic [15:0] lo, hi;
        logic [7:0]  proto;
        logic [19:0] meta;
        s = $urandom_range(0, 15);
        k = $urandom_range(0, 3);
        foreach (m[i]) m[i] = pick_mask();
        if ($urandom_range(0, 1)) begin
            dhi = sb.sess_v6_hi[s];
            dlo = sb.sess_v6_lo[s];
        end else begin
            dhi = {sb.sess_v4[s][31:0], 32'($urandom)};
            dlo = rnd64();
        end
        if ($urandom_range(0, 7) == 0) dhi = rnd64();
        push_wr(CMD_WR_FILTER, f, 4'd0, src_pool[k][0] & m[0]);
        push_wr(CMD_WR_FILTER, f, 4'd1, src_pool[k][1] & m[1]);
        push_wr(CMD_WR_FILTER, f, 4'd2, m[0]);
        push_wr(CMD_WR_FILTER, f, 4'd3, m[1]);
        push_wr(CMD_WR_FILTER, f, 4'd4, dhi & m[2]);
        push_wr(CMD_WR_FILTER, f, 4'd5, dlo & m[3]);
        push_wr(CMD_WR_FILTER, f, 4'd6, m[2]);
        push_wr(CMD_WR_FILTER, f, 4'd7, m[3]);
        lo = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 40000));
        hi = $urandom_range(0, 1) ? 16'd0 : lo + 16'($urandom_range(0, 25000));
        push_wr(CMD_WR_FILTER, f, FW_PORTS, $urandom_range(0, 3) == 0 ? rnd64()
                                                                       : {hi, lo, hi, lo});
        case ($urandom_range(0, 3))
            0: proto = 8'd0;
            1: proto = PROTO_TCP;
            2: proto = PROTO_UDP;
            default: proto = 8'($urandom);
        endcase
        meta = {$urandom_range(0, 5) != 0,
                $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'(s),
                proto, $urandom_range(0, 5) != 0, 4'($urandom)};
        push_wr(CMD_WR_FILTER, f, FW_META, {rnd64() & ~64'hF_FFFF} | 64'(meta));
        filt_full[f] = 1;
    endfunction

    function automatic void gen_classify();
        int          s, k;
        bit          v6;
        logic [63:0] dhi, dlo;
        logic [7:0]  proto;
        s = $urandom_range(0, 15);
        k = $urandom_range(0, 3);
        v6 = 1'($urandom);
        if (v6) begin
            dhi = sb.sess_v6_hi[s];
            dlo = sb.sess_v6_lo[s];
        end else begin
            dhi = {sb.sess_v4[s][31:0], 32'($urandom)};
            dlo = rnd64();
        end
        if ($urandom_range(0, 9) == 0) dhi = rnd64();
        case ($urandom_range(0, 3))
            0: proto = PROTO_TCP;
            1: proto = PROTO_UDP;
            2: proto = $urandom_range(0, 1) ? 8'd0 : 8'hFF;
            default: proto = 8'($urandom);
        endcase
        push_cls(v6, $urandom_range(0, 4) == 0 ? rnd64() : src_pool[k][0],
                 $urandom_range(0, 4) == 0 ? rnd64() : src_pool[k][1],
                 dhi, dlo, proto, 16'($urandom), 16'($urandom));
    endfunction

    // writes the block drops, plus rewrites that keep every read defined
    function automatic void gen_noise();
        t_in_item it;
        int       e;
        it = noise_item(CMD_WR_SESSION);
        case ($urandom_range(0, 5))
            0: it.cmd = CMD_NOP;
            1: it.entry_index = 6'($urandom_range(16, 63));
            2: it.word_index = 4'($urandom_range(4, 15));
            3: begin
                it.cmd = CMD_WR_FILTER;
                it.word_index = 4'($urandom_range(10, 15));
            end
            4: begin
                e = $urandom_range(0, 15);
                it.entry_index = 6'(e);
                it.word_index = SW_DEFAULT;
                if (!v6_written[e]) it.word_data[33] = 0;
            end
            default: begin
                e = $urandom_range(0, 63);
                it.cmd = CMD_WR_FILTER;
                it.entry_index = 6'(e);
                it.word_index = filt_full[e] ? 4'($urandom_range(0, 8)) : FW_META;
                if (!filt_full[e]) it.word_data[19] = 0;
            end
        endcase
        stim_q.push_back(it);
    endfunction

    task automatic send_item(t_in_item it);
        logic [IN_TW-1:0] w;
        int               gap;
        w = '0;
        w[IN_W-1:0] = it;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic drain_q();
        while (stim_q.size() > 0) send_item(stim_q.pop_front());
    endtask

    // result side with random stalls
    initial begin : rx_proc
        int gap;
        int n;
        n = 0;
        @(posedge i_rst_n);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            sb.check_result(o_m_axis_tdata);
            n++;
            if (n % 60 == 0) rx_burst = !rx_burst;
        end
    end

    initial begin : main_proc
        int wait_cnt;
        sb = new();
        i_clk = 0;
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 0;
        tx_burst = 0;
        rx_burst = 0;
        n_sent = 0;
        foreach (v4_pool[i]) begin
            v4_pool[i] = $urandom;
            v6_pool[i][0] = rnd64();
            v6_pool[i][1] = rnd64();
            src_pool[i][0] = rnd64();
            src_pool[i][1] = rnd64();
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tables, missing default, cross family, filters
        push_cls(1'b0, '1, '1, '1, '1, 8'hFF, 16'hFFFF, 16'hFFFF);
        push_wr(CMD_WR_SESSION, 0, SW_V4, {30'd0, 2'b01, 32'hFFFF_FFFF});
        push_cls(1'b0, '0, '0, 64'hFFFF_FFFF_0000_0000, '0, 8'd0, 16'd0, 16'd0);
        push_wr(CMD_WR_SESSION, 0, SW_DEFAULT, 64'h1F);
        push_cls(1'b0, '0, '0, '1, '1, PROTO_TCP, 16'd80, 16'd443);
        push_wr(CMD_WR_SESSION, 1, SW_V6_HI, '1);
        push_wr(CMD_WR_SESSION, 1, SW_V6_LO, '1);
        push_wr(CMD_WR_SESSION, 1, SW_V4, {30'd0, 2'b10, 32'hFFFF_FFFF});
        push_wr(CMD_WR_SESSION, 1, SW_DEFAULT, 64'h13);
        push_cls(1'b1, '0, '0, '1, '1, PROTO_UDP, 16'd1, 16'd1);
        push_wr(CMD_WR_SESSION, 63, SW_V4, '1);
        push_wr(CMD_WR_SESSION, 2, 4'd15, '1);
        push_wr(CMD_WR_FILTER, 5, 4'd15, '1);
        push_wr(CMD_NOP, 0, 4'd0, '1);
        for (int w = 0; w < 8; w++) push_wr(CMD_WR_FILTER, 0, 4'(w), '0);
        push_wr(CMD_WR_FILTER, 0, FW_PORTS, {16'd100, 16'd10, 16'hFFFF, 16'd1});
        push_wr(CMD_WR_FILTER, 0, FW_META, {44'd0, 1'b1, 6'd1, PROTO_TCP, 1'b1, 4'd9});
        filt_full[0] = 1;
        push_cls(1'b1, '0, '0, '1, '1, PROTO_TCP, 16'd5, 16'd100);
        push_cls(1'b1, '0, '0, '1, '1, PROTO_TCP, 16'd5, 16'd101);
        push_cls(1'b1, '0, '0, '1, '1, PROTO_TCP, 16'd0, 16'd50);
        drain_q();

        // random: mostly well-formed table programming and matching lookups
        while (n_sent < 850) begin
            case ($urandom_range(0, 9))
                0, 1: gen_session($urandom_range(0, 15));
                2, 3: gen_filter($urandom_range(0, 63));
                4: gen_noise();
                default: gen_classify();
            endcase
            drain_q();
            if (n_sent % 120 < 12) tx_burst = 1;
            else tx_burst = 0;
            if (n_sent > 400 && n_sent < 420) begin
                // hold off the input until every pending result is back
                i_s_axis_tvalid <= 1'b0;
                wait_cnt = 0;
                while (sb.exp_q.size() > 0 && wait_cnt < 100000) begin
                    @(posedge i_clk);
                    wait_cnt++;
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        wait_cnt = 0;
        while (sb.exp_q.size() > 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (700) @(posedge i_clk);
        if (sb.exp_q.size() > 0) begin
            $error("%0d results never arrived", sb.exp_q.size());
            sb.n_err++;
        end
        $display("Sent %0d items with %0d lookups: %0d found a session, %0d on dedicated bearers.",
                 n_sent, sb.n_cls, sb.n_found, sb.n_ded);
        if (sb.n_err == 0) begin
            $display("tb_downlink_packet_filter_classifier_top OK");
        end else begin
            $display("tb_downlink_packet_filter_classifier_top NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("tb_downlink_packet_filter_classifier_top NOT OK");
        $finish;
    end

endmodule
